@@ rtl/eckd_pkg.sv @@
// eckd_pkg: types, character codes and the per-character decode step
// for the key-string decoder. No dependencies.
package eckd_pkg;

	localparam int MAX_BYTES = 255;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int MAX_RES   = 3;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int QLW       = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_USC   = 8'h5F;
	localparam logic [7:0] CH_XL    = 8'h78;
	localparam logic [7:0] CH_XU    = 8'h58;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CTRL_LOW = 8'h60;

	typedef enum logic [3:0] {
		PH_NORM   = 4'd0,
		PH_CARET  = 4'd1,
		PH_ESC    = 4'd2,
		PH_ZERO   = 4'd3,
		PH_HEXS_L = 4'd4,
		PH_HEXS_U = 4'd5,
		PH_HEX    = 4'd6,
		PH_OCT    = 4'd7,
		PH_DEC    = 4'd8,
		PH_ERR    = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		K_BYTE  = 2'd0,
		K_DONE  = 2'd1,
		K_ERROR = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic [7:0] byte_count;
		logic       last;
	} res_t;

	typedef struct packed {
		phase_t           ph;
		logic [8:0]       acc;
		logic [CNT_W-1:0] cnt;
	} st_t;

	typedef struct packed {
		st_t                     st;
		res_t [MAX_RES-1:0]      res;
		logic [1:0]              n;
	} step_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         n;
	} push_t;

	typedef struct packed {
		logic           nonempty;
		logic           room;
		logic [QLW-1:0] level;
	} q_stat_t;

	function automatic step_t put_res(step_t s, logic [7:0] b, kind_t k, logic [7:0] nb);
		step_t r;
		r = s;
		r.res[r.n] = '{out_byte: b, kind: k, byte_count: nb, last: 1'b0};
		r.n = r.n + 2'd1;
		return r;
	endfunction

	function automatic step_t emit_b(step_t s, logic [7:0] b);
		step_t r;
		r = s;
		if (r.st.ph != PH_ERR) begin
			if (r.st.cnt >= CNT_W'(MAX_BYTES)) begin
				r.st.ph = PH_ERR;
			end else begin
				r = put_res(r, b, K_BYTE, 8'd0);
				r.st.cnt = r.st.cnt + 1'b1;
			end
		end
		return r;
	endfunction

	function automatic step_t end_tok(step_t s, logic err);
		step_t r;
		r = s;
		if (err)
			r = put_res(r, 8'd0, K_ERROR, 8'd0);
		else
			r = put_res(r, 8'd0, K_DONE, 8'(r.st.cnt));
		r.st.ph  = PH_NORM;
		r.st.acc = '0;
		r.st.cnt = '0;
		return r;
	endfunction

	function automatic step_t norm_pass(step_t s, logic [7:0] c);
		step_t r;
		r = s;
		r.st.ph = PH_NORM;
		priority if (c == CH_NUL)
			r = end_tok(r, r.st.cnt == '0);
		else if (c == CH_CARET)
			r.st.ph = PH_CARET;
		else if (c == CH_BSL)
			r.st.ph = PH_ESC;
		else
			r = emit_b(r, c);
		return r;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [4:0] h;
		h = '0;
		priority if (c >= CH_0 && c <= CH_9)
			h = {1'b1, 4'(c - CH_0)};
		else if (c >= CH_LA && c <= CH_LF)
			h = {1'b1, 4'(c - CH_LA + 8'd10)};
		else if (c >= CH_UA && c <= CH_UF)
			h = {1'b1, 4'(c - CH_UA + 8'd10)};
		else
			h = '0;
		return h;
	endfunction

	function automatic step_t step(st_t st, logic [7:0] c);
		step_t      s;
		logic       again;
		logic [4:0] hv;
		logic [4:0] base;
		logic [12:0] a13;
		logic [12:0] nv;
		logic [7:0] v;
		s = '0;
		s.st = st;
		again = 1'b0;
		hv = hex_val(c);
		a13 = {4'b0, st.acc};
		base = 5'd10;
		nv = '0;
		v = '0;
		unique case (st.ph)
			PH_ERR: begin
				if (c == CH_NUL)
					s = end_tok(s, 1'b1);
			end
			PH_CARET: begin
				priority if (c == CH_NUL) begin
					s = end_tok(s, 1'b1);
				end else if (c == CH_QUEST) begin
					s.st.ph = PH_NORM;
					s = emit_b(s, CH_DEL);
				end else if (c >= CH_LA && c <= CH_LZ) begin
					s.st.ph = PH_NORM;
					s = emit_b(s, c - CTRL_LOW);
				end else if (c >= CH_AT && c <= CH_USC) begin
					s.st.ph = PH_NORM;
					s = emit_b(s, c - CH_AT);
				end else begin
					s.st.ph = PH_ERR;
				end
			end
			PH_ESC: begin
				priority if (c == CH_NUL) begin
					s = end_tok(s, 1'b1);
				end else if (c == CH_0) begin
					s.st.acc = '0;
					s.st.ph  = PH_ZERO;
				end else if (c >= CH_1 && c <= CH_9) begin
					s.st.acc = {1'b0, c - CH_0};
					s.st.ph  = PH_DEC;
				end else begin
					unique case (c)
						CH_B:    v = 8'd8;
						CH_F:    v = 8'd12;
						CH_N:    v = 8'd10;
						CH_R:    v = 8'd13;
						CH_S:    v = 8'd32;
						CH_T:    v = 8'd9;
						default: v = c;
					endcase
					s.st.ph = PH_NORM;
					s = emit_b(s, v);
				end
			end
			PH_ZERO: begin
				priority if (c == CH_XL) begin
					s.st.ph = PH_HEXS_L;
				end else if (c == CH_XU) begin
					s.st.ph = PH_HEXS_U;
				end else if (c >= CH_0 && c <= CH_7) begin
					s.st.acc = {1'b0, c - CH_0};
					s.st.ph  = PH_OCT;
				end else begin
					s.st.ph = PH_NORM;
					s = emit_b(s, 8'd0);
					again = 1'b1;
				end
			end
			PH_HEXS_L, PH_HEXS_U: begin
				if (hv[4]) begin
					s.st.acc = {5'b0, hv[3:0]};
					s.st.ph  = PH_HEX;
				end else begin
					v = (st.ph == PH_HEXS_L) ? CH_XL : CH_XU;
					s.st.ph = PH_NORM;
					s = emit_b(s, 8'd0);
					s = emit_b(s, v);
					again = 1'b1;
				end
			end
			PH_HEX, PH_OCT, PH_DEC: begin
				unique case (st.ph)
					PH_HEX: begin
						base = 5'd16;
						nv = a13 << 4;
					end
					PH_OCT: begin
						base = 5'd8;
						nv = a13 << 3;
					end
					default: begin
						base = 5'd10;
						nv = (a13 << 3) + (a13 << 1);
					end
				endcase
				nv = nv + {9'b0, hv[3:0]};
				if (hv[4] && ({1'b0, hv[3:0]} < base)) begin
					if (nv > 13'd255) begin
						s.st.acc = '0;
						s.st.ph  = PH_ERR;
					end else begin
						s.st.acc = nv[8:0];
					end
				end else begin
					s.st.acc = '0;
					s.st.ph  = PH_NORM;
					s = emit_b(s, st.acc[7:0]);
					again = 1'b1;
				end
			end
			default: s = norm_pass(s, c);
		endcase
		// character that ends a number or prefix goes round once more
		if (again) begin
			if (s.st.ph == PH_ERR) begin
				if (c == CH_NUL)
					s = end_tok(s, 1'b1);
			end else begin
				s = norm_pass(s, c);
			end
		end
		if (s.n != 2'd0)
			s.res[s.n - 2'd1].last = 1'b1;
		return s;
	endfunction

endpackage

@@ rtl/escape_caret_key_string_decoder.sv @@
// escape_caret_key_string_decoder: top level of the key-string decoder.
// Uses eckd_pkg, eckd_front, eckd_queue, eckd_back.
//
// Takes one token character per cycle (0 ends the token) and returns the
// decoded bytes, then a done or error result at the terminator, one result
// per cycle unless res_stall is set, with last marking the final result of
// each character. A character is decoded in the cycle it is accepted; its
// results go through the result queue into the output register. The front
// takes a character only while the four-entry queue has room for three
// results: one-result characters stream at one per cycle while res_stall is
// low; two- or three-result ones hold input off until the output drains.
module escape_caret_key_string_decoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ch_valid,
	output logic            ch_stall,
	input  logic [7:0]      ch,
	output logic            res_valid,
	input  logic            res_stall,
	output logic [7:0]      out_byte,
	output eckd_pkg::kind_t kind,
	output logic [7:0]      byte_count,
	output logic            last
);
	import eckd_pkg::*;

	push_t   push;
	q_stat_t q_stat;
	res_t    head;
	res_t    res;
	logic    pop;

	eckd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch_valid (ch_valid),
		.ch_stall (ch_stall),
		.ch       (ch),
		.q_stat   (q_stat),
		.push     (push)
	);

	eckd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	eckd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_nonempty (q_stat.nonempty),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	assign out_byte   = res.out_byte;
	assign kind       = res.kind;
	assign byte_count = res.byte_count;
	assign last       = res.last;

`ifndef SYNTH
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.level <= QLW'(QDEPTH))
		else $error("result queue overfilled");

	a_term_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_valid && !ch_stall && ch == CH_NUL) |->
		(push.n != 2'd0 && push.res[push.n - 2'd1].kind != K_BYTE))
		else $error("terminator gave no done or error result");

	a_mid_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(ch_valid && !ch_stall && ch != CH_NUL && push.n != 2'd0) |->
		(push.res[push.n - 2'd1].kind == K_BYTE))
		else $error("token ended before its terminator");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind != K_BYTE) |-> (out_byte == 8'd0))
		else $error("status result carries a byte");
`endif

endmodule

@@ rtl/eckd_front.sv @@
// eckd_front: token state and per-character decode; pushes up to three
// results a character into the result queue. Uses eckd_pkg.
module eckd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ch_valid,
	output logic             ch_stall,
	input  logic [7:0]       ch,
	input  eckd_pkg::q_stat_t q_stat,
	output eckd_pkg::push_t  push
);
	import eckd_pkg::*;

	st_t   st_q;
	step_t nxt;
	logic  accept;

	assign ch_stall = !q_stat.room;
	assign accept   = ch_valid && !ch_stall;

	always_comb begin
		nxt = step(st_q, ch);
	end

	assign push.res = nxt.res;
	assign push.n   = accept ? nxt.n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{ph: PH_NORM, acc: '0, cnt: '0};
		end else if (accept) begin
			st_q <= nxt.st;
		end
	end

endmodule

@@ rtl/eckd_queue.sv @@
// eckd_queue: small result queue between decode and output stage;
// multi-entry push, single pop. Uses eckd_pkg.
module eckd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  eckd_pkg::push_t   push,
	input  logic              pop,
	output eckd_pkg::res_t    head,
	output eckd_pkg::q_stat_t q_stat
);
	import eckd_pkg::*;

	res_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QLW-1:0] lvl_q;

	assign head            = mem_q[rd_ptr_q];
	assign q_stat.nonempty = lvl_q != '0;
	assign q_stat.room     = lvl_q <= QLW'(QDEPTH - MAX_RES);
	assign q_stat.level    = lvl_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.n)
				mem_q[wr_ptr_q + QAW'(i)] <= push.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			lvl_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push.n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			lvl_q <= lvl_q + QLW'(push.n) - QLW'(pop);
		end
	end

endmodule

@@ rtl/eckd_back.sv @@
// eckd_back: output register of the result channel, refilled from the
// queue head whenever it is empty or being taken. Uses eckd_pkg.
module eckd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  eckd_pkg::res_t head,
	input  logic           q_nonempty,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_stall,
	output eckd_pkg::res_t res
);
	import eckd_pkg::*;

	res_t res_q;
	logic valid_q;

	assign pop       = q_nonempty && (!valid_q || !res_stall);
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (pop)
			res_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

@@ test/testbench.sv @@
// testbench: streams key-description tokens into escape_caret_key_string_decoder and checks
// each result against a cycle-free decoder model kept here. Needs eckd_pkg and the block RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import eckd_pkg::*;

	localparam int         BYTE_LIMIT  = MAX_BYTES;
	localparam int         CYCLE_LIMIT = 500000;
	localparam logic [7:0] END_MARK    = 8'h00;

	typedef enum logic [3:0] {
		S_PLAIN, S_CARET, S_ESC, S_ZERO, S_HEXPRE_L, S_HEXPRE_U, S_HEX, S_OCT, S_DEC, S_FAULT
	} scan_t;

	typedef struct {
		logic [7:0] value;
		kind_t      kind;
		logic [7:0] count;
		logic       last;
	} decoded_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       ch_valid = 1'b0;
	logic       ch_stall;
	logic [7:0] ch = 8'h00;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] out_byte;
	kind_t      kind;
	logic [7:0] byte_count;
	logic       last;

	logic [7:0] char_queue[$];
	decoded_t   due_results[$];

	scan_t scan_state = S_PLAIN;
	int    num_acc = 0;
	int    byte_total = 0;

	int send_gap = 0, send_calm = 0, stall_left = 0, sink_calm = 0;
	int mismatches = 0, cycle_count = 0;
	int chars_taken = 0, tokens_taken = 0, bytes_seen = 0, done_seen = 0, errors_seen = 0;

	escape_caret_key_string_decoder dut (
		.clk, .arst_n, .ch_valid, .ch_stall, .ch,
		.res_valid, .res_stall, .out_byte, .kind, .byte_count, .last
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- decoder model ----------------

	function automatic void expect_result(logic [7:0] value, kind_t k, logic [7:0] cnt);
		decoded_t r;
		r.value = value;
		r.kind  = k;
		r.count = cnt;
		r.last  = 1'b0;
		due_results.push_back(r);
	endfunction

	function automatic void emit_byte(int value);
		if (scan_state != S_FAULT) begin
			if (byte_total >= BYTE_LIMIT) begin
				scan_state = S_FAULT;
			end else begin
				expect_result(8'(value), K_BYTE, 8'd0);
				byte_total++;
			end
		end
	endfunction

	function automatic void close_token(bit bad);
		if (bad)
			expect_result(8'd0, K_ERROR, 8'd0);
		else
			expect_result(8'd0, K_DONE, 8'(byte_total));
		scan_state = S_PLAIN;
		num_acc    = 0;
		byte_total = 0;
	endfunction

	function automatic int digit_value(int c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		return -1;
	endfunction

	function automatic void decode_char(logic [7:0] ch_in);
		int c, base, d, v, first;
		bit again;
		c = ch_in;
		first = due_results.size();
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			case (scan_state)
				S_FAULT: begin
					if (c == 0)
						close_token(1'b1);
				end
				S_CARET: begin
					if (c == 0) begin
						close_token(1'b1);
					end else if (c == "?") begin
						scan_state = S_PLAIN;
						emit_byte(8'h7F);
					end else if (c >= "a" && c <= "z") begin
						scan_state = S_PLAIN;
						emit_byte(c - "a" + 1);
					end else if (c >= "@" && c <= "_") begin
						scan_state = S_PLAIN;
						emit_byte(c - "@");
					end else begin
						scan_state = S_FAULT;
					end
				end
				S_ESC: begin
					if (c == 0) begin
						close_token(1'b1);
					end else if (c == "0") begin
						num_acc    = 0;
						scan_state = S_ZERO;
					end else if (c >= "1" && c <= "9") begin
						num_acc    = c - "0";
						scan_state = S_DEC;
					end else begin
						case (c)
							"b":     v = 8;
							"f":     v = 12;
							"n":     v = 10;
							"r":     v = 13;
							"s":     v = 32;
							"t":     v = 9;
							default: v = c;
						endcase
						scan_state = S_PLAIN;
						emit_byte(v);
					end
				end
				S_ZERO: begin
					if (c == "x") begin
						scan_state = S_HEXPRE_L;
					end else if (c == "X") begin
						scan_state = S_HEXPRE_U;
					end else if (c >= "0" && c <= "7") begin
						num_acc    = c - "0";
						scan_state = S_OCT;
					end else begin
						scan_state = S_PLAIN;
						emit_byte(0);
						again = 1'b1;
					end
				end
				S_HEXPRE_L, S_HEXPRE_U: begin
					d = digit_value(c);
					if (d >= 0) begin
						num_acc    = d;
						scan_state = S_HEX;
					end else begin
						v = (scan_state == S_HEXPRE_L) ? "x" : "X";
						scan_state = S_PLAIN;
						emit_byte(0);
						emit_byte(v);
						again = 1'b1;
					end
				end
				S_HEX, S_OCT, S_DEC: begin
					base = (scan_state == S_HEX) ? 16 : (scan_state == S_OCT) ? 8 : 10;
					d = digit_value(c);
					if (d < 0 || d >= base) begin
						v = num_acc;
						num_acc    = 0;
						scan_state = S_PLAIN;
						emit_byte(v);
						again = 1'b1;
					end else begin
						num_acc = num_acc * base + d;
						if (num_acc > 255) begin
							num_acc    = 0;
							scan_state = S_FAULT;
						end
					end
				end
				default: begin
					scan_state = S_PLAIN;
					if (c == 0)
						close_token(byte_total == 0);
					else if (c == "^")
						scan_state = S_CARET;
					else if (c == "\\")
						scan_state = S_ESC;
					else
						emit_byte(c);
				end
			endcase
		end
		if (due_results.size() > first)
			due_results[due_results.size() - 1].last = 1'b1;
	endfunction

	// ---------------- stimulus ----------------

	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		c = 8'($urandom_range(1, 255));
		if (c == "^" || c == "\\")
			c = "A";
		return c;
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			char_queue.push_back(s[i]);
	endtask

	task automatic add_piece();
		string      hex_digits;
		string      esc_letters;
		int         sel, r, n;
		logic [7:0] c;
		hex_digits  = "0123456789abcdefABCDEF";
		esc_letters = "bfnrst";
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			n = $urandom_range(1, 3);
			repeat (n)
				char_queue.push_back(plain_char());
		end else if (sel < 45) begin
			char_queue.push_back("^");
			r = $urandom_range(0, 9);
			if (r == 0)
				c = "?";
			else if (r < 5)
				c = 8'("a" + $urandom_range(0, 25));
			else if (r < 8)
				c = 8'("@" + $urandom_range(0, 31));
			else if (r == 8)
				c = 8'($urandom_range(1, 255));
			else
				c = 8'($urandom_range(1, 62));
			char_queue.push_back(c);
		end else if (sel < 57) begin
			char_queue.push_back("\\");
			if ($urandom_range(0, 1)) begin
				c = esc_letters[$urandom_range(0, 5)];
			end else begin
				c = 8'($urandom_range(1, 255));
				if (c >= "0" && c <= "9")
					c = "q";
			end
			char_queue.push_back(c);
		end else if (sel < 67) begin
			push_text("\\");
			char_queue.push_back(8'("1" + $urandom_range(0, 8)));
			n = $urandom_range(0, 2);
			repeat (n)
				char_queue.push_back(8'("0" + $urandom_range(0, 9)));
		end else if (sel < 77) begin
			push_text("\\0");
			n = $urandom_range(0, 3);
			repeat (n)
				char_queue.push_back(8'("0" + $urandom_range(0, 7)));
			if ($urandom_range(0, 3) == 0)
				char_queue.push_back(8'("8" + $urandom_range(0, 1)));
		end else if (sel < 90) begin
			push_text($urandom_range(0, 1) ? "\\0x" : "\\0X");
			n = $urandom_range(0, 3);
			repeat (n)
				char_queue.push_back(hex_digits[$urandom_range(0, 21)]);
		end else begin
			push_text("\\0");
		end
	endtask

	task automatic add_token();
		int r, n;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			n = $urandom_range(1, 8);
			repeat (n)
				char_queue.push_back(8'($urandom_range(1, 255)));
		end else if (r >= 15) begin
			n = $urandom_range(1, 6);
			repeat (n)
				add_piece();
			if ($urandom_range(0, 9) == 0)
				push_text($urandom_range(0, 1) ? "^" : "\\");
		end
		char_queue.push_back(END_MARK);
	endtask

	// ---------------- request side ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_valid <= 1'b0;
			ch       <= 8'h00;
		end else begin
			if (ch_valid && !ch_stall) begin
				decode_char(ch);
				chars_taken++;
				if (ch == END_MARK)
					tokens_taken++;
			end
			if (!ch_valid || !ch_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					ch_valid <= 1'b0;
				end else if (char_queue.size() != 0) begin
					ch       <= char_queue.pop_front();
					ch_valid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					ch_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result side ----------------

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				case (kind)
					K_BYTE:  bytes_seen++;
					K_DONE:  done_seen++;
					default: errors_seen++;
				endcase
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: byte %02h kind %0d count %0d last %0d",
							out_byte, kind, byte_count, last);
				end else begin
					want = due_results.pop_front();
					if (out_byte !== want.value || kind !== want.kind ||
						byte_count !== want.count || last !== want.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: expected byte %02h kind %0d count %0d last %0d,",
								" got byte %02h kind %0d count %0d last %0d"},
								want.value, want.kind, want.count, want.last,
								out_byte, kind, byte_count, last);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				stall_left = pick_gap(sink_calm);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, due_results.size());
			$display("FAIL escape_caret_key_string_decoder");
			$finish;
		end
	end

	initial begin
		// empty token, then 0xff and ^? before a decimal escape that overflows
		char_queue.push_back(END_MARK);
		char_queue.push_back(8'hFF);
		push_text("^?\\999");
		char_queue.push_back(END_MARK);
		// trailing caret, trailing backslash, bad caret
		push_text("^");
		char_queue.push_back(END_MARK);
		push_text("\\");
		char_queue.push_back(END_MARK);
		push_text("^!");
		char_queue.push_back(END_MARK);
		// hex prefix with no digits, octal cut short by 8, then a letter escape
		push_text("\\0xz");
		char_queue.push_back(END_MARK);
		push_text("\\018\\n");
		char_queue.push_back(END_MARK);

		while (char_queue.size() < 200)
			add_token();

		// token that runs past the byte limit mid-prefix
		repeat (BYTE_LIMIT - 1)
			char_queue.push_back(plain_char());
		push_text("\\0xg");
		char_queue.push_back(END_MARK);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (char_queue.size() != 0 || ch_valid)
			@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d characters in %0d tokens: %0d bytes, %0d done and %0d error results",
			chars_taken, tokens_taken, bytes_seen, done_seen, errors_seen);
		$display("%0d mismatches, %0d results outstanding", mismatches, due_results.size());
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("PASS escape_caret_key_string_decoder");
		end else begin
			$display("FAIL escape_caret_key_string_decoder");
		end
		$finish;
	end

endmodule
